>>> rtl/core/fhp_pkg.sv
// Package for the fragment header parser: header layout constants, status codes,
// item types and the digit helper functions.
// Depends on nothing; every other file of the block imports it.
package fhp_pkg;

   // Header layout: index digits, separator, count digits, separator.
   localparam int INDEX_DIGITS = 2;
   localparam int COUNT_DIGITS = 2;
   localparam int HDR_LEN      = INDEX_DIGITS + 1 + COUNT_DIGITS + 1;
   localparam int POS_W        = $clog2(HDR_LEN);

   // Field widths.
   localparam int BYTE_W   = 8;
   localparam int ACC_W    = 11;
   localparam int DIGIT_W  = 6;
   // Widest value of acc * 36 + 35 before saturation.
   localparam int WIDE_W   = ACC_W + DIGIT_W;

   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   // ASCII codes for the digit ranges.
   localparam logic [BYTE_W-1:0] CHAR_0 = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_9 = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_Z = 8'h5A;
   localparam logic [DIGIT_W-1:0] LETTER_BASE = 6'd10;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_BAD_SEP   = 3'd2,
      ST_BAD_DIGIT = 3'd3,
      ST_BAD_COUNT = 3'd4
   } status_type;

   // Payload of one input item.
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              is_last;
   } req_item_type;

   // Payload of one result item.
   typedef struct packed {
      status_type       status;
      logic [ACC_W-1:0] frag_index;
      logic [ACC_W-1:0] frag_count;
   } rsp_item_type;

   // True when the byte is an uppercase base-36 digit.
   function automatic logic is_digit(input logic [BYTE_W-1:0] b);
      is_digit = ((b >= CHAR_0) && (b <= CHAR_9)) || ((b >= CHAR_A) && (b <= CHAR_Z));
   endfunction

   // Digit value 0..35; only meaningful when is_digit holds.
   function automatic logic [DIGIT_W-1:0] digit_value(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] diff;
      if (b <= CHAR_9) begin
         diff = b - CHAR_0;
         digit_value = diff[DIGIT_W-1:0];
      end else begin
         diff = b - CHAR_A;
         digit_value = diff[DIGIT_W-1:0] + LETTER_BASE;
      end
   endfunction

   // acc * 36 + d, saturating at the accumulator's largest value.
   function automatic logic [ACC_W-1:0] acc_step(input logic [ACC_W-1:0] acc,
                                                 input logic [DIGIT_W-1:0] d);
      logic [WIDE_W-1:0] wide;
      wide = ({{DIGIT_W{1'b0}}, acc} << 5) + ({{DIGIT_W{1'b0}}, acc} << 2)
           + {{ACC_W{1'b0}}, d};
      if (wide > {{DIGIT_W{1'b0}}, ACC_MAX}) begin
         acc_step = ACC_MAX;
      end else begin
         acc_step = wide[ACC_W-1:0];
      end
   endfunction

endpackage

>>> rtl/core/fhp_if.sv
// Channel interfaces for the fragment header parser: byte input, result output and
// separator register write. Each carries valid, ready and its payload.
// Depends on fhp_pkg for field widths and the status type.
interface fhp_req_if;
   import fhp_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              is_last;
   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface fhp_rsp_if;
   import fhp_pkg::*;
   logic             valid;
   logic             ready;
   status_type       status;
   logic [ACC_W-1:0] frag_index;
   logic [ACC_W-1:0] frag_count;
   modport source (output valid, output status, output frag_index, output frag_count,
                   input ready);
   modport sink   (input valid, input status, input frag_index, input frag_count,
                   output ready);
endinterface

interface fhp_csr_if;
   import fhp_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] separator_char;
   modport source (output valid, output separator_char, input ready);
   modport sink   (input valid, input separator_char, output ready);
endinterface

>>> rtl/core/fhp_in_reg.sv
// Input register of the fragment header parser: holds one accepted byte item until
// the parse stage takes it. Depends on fhp_pkg.
module fhp_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  fhp_pkg::req_item_type in_item,
   output logic                  out_valid,
   input  logic                  out_take,
   output fhp_pkg::req_item_type out_item
);
   import fhp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // The register frees up in the same cycle that the parse stage takes its item.
   assign in_ready = !valid_ff || out_take;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads on every accepted item.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

>>> rtl/core/fhp_parse.sv
// Parse stage of the fragment header parser: per-fragment state, digit accumulation,
// separator checks and result formation for one byte item per cycle, unless a result waits for room.
// Depends on fhp_pkg.
module fhp_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [7:0]            csr_data,
   input  logic                  item_valid,
   input  fhp_pkg::req_item_type item,
   output logic                  item_take,
   input  logic                  rsp_free,
   output logic                  rsp_load,
   output fhp_pkg::rsp_item_type rsp_item
);
   import fhp_pkg::*;

   localparam logic [POS_W-1:0] POS_SEP1 = POS_W'(INDEX_DIGITS);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(HDR_LEN - 1);

   logic [BYTE_W-1:0] sep_ff;
   logic [POS_W-1:0]  pos_ff,   pos_in;
   logic [ACC_W-1:0]  idx_ff,   idx_in;
   logic [ACC_W-1:0]  cnt_ff,   cnt_in;
   logic              serr_ff,  serr_in;
   logic              derr_ff,  derr_in;
   logic              done_ff,  done_in;

   logic              emit;
   logic              good_digit;
   logic [DIGIT_W-1:0] dval;
   logic              sep_bad;
   logic              serr_final;
   status_type        st;

   // Separator register; the user must write it only while the block is idle (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= '0;
      end else if (csr_write) begin
         sep_ff <= csr_data;
      end
   end

   assign good_digit = is_digit(item.data_byte);
   assign dval       = digit_value(item.data_byte);
   assign sep_bad    = item.data_byte != sep_ff;
   assign serr_final = serr_ff || sep_bad;

   // Status of a completed header: separator, then digit, then count checks.
   always_comb begin
      if (serr_final) begin
         st = ST_BAD_SEP;
      end else if (derr_ff) begin
         st = ST_BAD_DIGIT;
      end else if ((cnt_ff == '0) || (idx_ff >= cnt_ff)) begin
         st = ST_BAD_COUNT;
      end else begin
         st = ST_OK;
      end
   end

   // Next fragment state and the result this byte produces, if any.
   always_comb begin
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      serr_in  = serr_ff;
      derr_in  = derr_ff;
      done_in  = done_ff;
      emit     = 1'b0;
      rsp_item = '{status: ST_SHORT, frag_index: '0, frag_count: '0};
      if (!done_ff) begin
         if (pos_ff == POS_LAST) begin
            serr_in  = serr_final;
            done_in  = 1'b1;
            emit     = 1'b1;
            rsp_item.status = st;
            if (st == ST_OK) begin
               rsp_item.frag_index = idx_ff;
               rsp_item.frag_count = cnt_ff;
            end
         end else begin
            if (pos_ff < POS_SEP1) begin
               if (good_digit) begin
                  idx_in = acc_step(idx_ff, dval);
               end else begin
                  derr_in = 1'b1;
               end
            end else if (pos_ff == POS_SEP1) begin
               if (sep_bad) begin
                  serr_in = 1'b1;
               end
            end else begin
               if (good_digit) begin
                  cnt_in = acc_step(cnt_ff, dval);
               end else begin
                  derr_in = 1'b1;
               end
            end
            pos_in = pos_ff + 1'b1;
            // Fragment ended before its header did.
            if (item.is_last) begin
               emit = 1'b1;
            end
         end
      end
      // The last byte readies the parser for the next fragment.
      if (item.is_last) begin
         pos_in  = '0;
         idx_in  = '0;
         cnt_in  = '0;
         serr_in = 1'b0;
         derr_in = 1'b0;
         done_in = 1'b0;
      end
   end

   // An item that yields a result waits for room in the output register.
   assign item_take = item_valid && (!emit || rsp_free);
   assign rsp_load  = item_take && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         idx_ff  <= '0;
         cnt_ff  <= '0;
         serr_ff <= 1'b0;
         derr_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (item_take) begin
         pos_ff  <= pos_in;
         idx_ff  <= idx_in;
         cnt_ff  <= cnt_in;
         serr_ff <= serr_in;
         derr_ff <= derr_in;
         done_ff <= done_in;
      end
   end

endmodule

>>> rtl/core/fhp_out_reg.sv
// Output register of the fragment header parser: holds one result item until the
// consumer takes it. Depends on fhp_pkg.
module fhp_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  fhp_pkg::rsp_item_type load_item,
   output logic                  free,
   output logic                  out_valid,
   input  logic                  out_ready,
   output fhp_pkg::rsp_item_type out_item
);
   import fhp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // Room for a new result when empty or when the held one leaves this cycle.
   assign free     = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

>>> rtl/core/fragment_header_parser.sv
// Top level of the fragment header parser: input register, parse stage and output
// register. Depends on fhp_pkg, the fhp interfaces and the fhp_* modules.
//
//   Port     Direction  Payload                               Moves
//   req_ch   in         data_byte, is_last                    one fragment byte
//   rsp_ch   out        status, frag_index, frag_count        one header result
//   csr_ch   in         separator_char                        separator register write
//
// One byte item is accepted per cycle while the input register has room. A result is
// loaded into the output register when the parse stage takes the byte that completes (or
// cuts short) a header, so it passes the input register and then the output register.
// While a result waits, bytes that yield no result still pass through; a byte that
// yields one waits in the input register, which then refuses new bytes.
// Synchronous reset clears the separator to zero and the fragment state.
module fragment_header_parser (
   input logic       clock,
   input logic       reset,
   fhp_req_if.sink   req_ch,
   fhp_rsp_if.source rsp_ch,
   fhp_csr_if.sink   csr_ch
);
   import fhp_pkg::*;

   req_item_type req_item;
   req_item_type stage_item;
   rsp_item_type parse_item;
   rsp_item_type out_item;
   logic         stage_valid;
   logic         stage_take;
   logic         rsp_free;
   logic         rsp_load;
   logic         req_ready;

   assign req_item.data_byte = req_ch.data_byte;
   assign req_item.is_last   = req_ch.is_last;
   assign req_ch.ready       = req_ready;

   // The separator register takes a write in any cycle.
   assign csr_ch.ready = 1'b1;

   fhp_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (stage_valid),
      .out_take  (stage_take),
      .out_item  (stage_item)
   );

   fhp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_ch.valid),
      .csr_data   (csr_ch.separator_char),
      .item_valid (stage_valid),
      .item       (stage_item),
      .item_take  (stage_take),
      .rsp_free   (rsp_free),
      .rsp_load   (rsp_load),
      .rsp_item   (parse_item)
   );

   fhp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_item (parse_item),
      .free      (rsp_free),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_item  (out_item)
   );

   assign rsp_ch.status     = out_item.status;
   assign rsp_ch.frag_index = out_item.frag_index;
   assign rsp_ch.frag_count = out_item.frag_count;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for the fragment header parser: drives fragment bytes, separator writes and
// result back-pressure, and checks every result against a cycle-free header predictor.
// Depends on fhp_pkg, the fhp channel interfaces and the fragment_header_parser RTL.
module testbench;
   import fhp_pkg::*;

   typedef logic [BYTE_W-1:0] byte_queue_type[$];

   logic clock = 1'b0;
   logic reset;

   // Shared pacing controls: a steady phase disables idling on both sides, and the
   // receiver holds off while rsp_hold_cycles counts down.
   bit steady_phase = 1'b0;
   int rsp_hold_cycles = 0;

   fhp_req_if req_ch ();
   fhp_rsp_if rsp_ch ();
   fhp_csr_if csr_ch ();

   fragment_header_parser i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // Value of an uppercase base-36 digit, or 36 when the byte is no digit.
   function automatic int char_weight(input logic [BYTE_W-1:0] b);
      if (b >= CHAR_0 && b <= CHAR_9) begin
         return int'(b - CHAR_0);
      end
      if (b >= CHAR_A && b <= CHAR_Z) begin
         return int'(b - CHAR_A) + 10;
      end
      return 36;
   endfunction

   function automatic logic [BYTE_W-1:0] digit_char(input int v);
      return (v < 10) ? 8'(int'(CHAR_0) + v) : 8'(int'(CHAR_A) + v - 10);
   endfunction

   // Random idling decision, shared by the sender and the receiver.
   function automatic bit take_break();
      return !steady_phase && ($urandom_range(99) < 18);
   endfunction

   // Predicts header results from accepted bytes and checks the results that arrive.
   class header_scoreboard_type;
      logic [BYTE_W-1:0] separator;
      int                position;
      logic [ACC_W-1:0]  index_acc;
      logic [ACC_W-1:0]  count_acc;
      bit                sep_bad;
      bit                digit_bad;
      bit                reported;
      rsp_item_type      expected_results[$];
      int                faults;

      function new();
         separator = '0;
         faults = 0;
         clear_fragment();
      endfunction

      function void clear_fragment();
         position = 0;
         index_acc = '0;
         count_acc = '0;
         sep_bad = 1'b0;
         digit_bad = 1'b0;
         reported = 1'b0;
      endfunction

      function void set_separator(input logic [BYTE_W-1:0] s);
         separator = s;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void log_fault(input string msg);
         faults++;
         if (faults <= 10) begin
            $display("%s", msg);
         end
      endfunction

      // A bad digit raises the sticky flag and leaves the accumulator alone.
      function logic [ACC_W-1:0] add_digit(input logic [ACC_W-1:0] acc,
                                           input logic [BYTE_W-1:0] b);
         int d;
         int sum;
         d = char_weight(b);
         if (d == 36) begin
            digit_bad = 1'b1;
            return acc;
         end
         sum = int'(acc) * 36 + d;
         return (sum > int'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
      endfunction

      // Notes one accepted byte and queues the result it causes, if any.
      function void note_byte(input logic [BYTE_W-1:0] b, input bit last);
         rsp_item_type r;
         if (!reported) begin
            if (position < INDEX_DIGITS) begin
               index_acc = add_digit(index_acc, b);
            end else if (position == INDEX_DIGITS) begin
               sep_bad = sep_bad | (b != separator);
            end else if (position < HDR_LEN - 1) begin
               count_acc = add_digit(count_acc, b);
            end else begin
               // Final separator: separator errors win over digit errors, which win
               // over the count check.
               sep_bad = sep_bad | (b != separator);
               r = '0;
               if (sep_bad) begin
                  r.status = ST_BAD_SEP;
               end else if (digit_bad) begin
                  r.status = ST_BAD_DIGIT;
               end else if (count_acc == 0 || index_acc >= count_acc) begin
                  r.status = ST_BAD_COUNT;
               end else begin
                  r.status = ST_OK;
                  r.frag_index = index_acc;
                  r.frag_count = count_acc;
               end
               expected_results.push_back(r);
               reported = 1'b1;
            end
            if (!reported) begin
               position++;
               // The fragment ended before its header did.
               if (last) begin
                  r = '0;
                  r.status = ST_SHORT;
                  expected_results.push_back(r);
               end
            end
         end
         if (last) begin
            clear_fragment();
         end
      endfunction

      function void check_result(input rsp_item_type got);
         rsp_item_type want;
         if (expected_results.size() == 0) begin
            log_fault($sformatf("unexpected result: status %0d index %0d count %0d",
                                got.status, got.frag_index, got.frag_count));
            return;
         end
         want = expected_results.pop_front();
         if (got.status !== want.status || got.frag_index !== want.frag_index ||
             got.frag_count !== want.frag_count) begin
            log_fault($sformatf(
               "result mismatch: status %0d/%0d index %0d/%0d count %0d/%0d (exp/act)",
               want.status, got.status, want.frag_index, got.frag_index,
               want.frag_count, got.frag_count));
         end
      endfunction
   endclass

   header_scoreboard_type sb = new();

   // Offers one byte, with random idle cycles first, and waits until it is taken.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit last);
      while (take_break()) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.is_last <= last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) begin
         @(posedge clock);
      end
      sb.note_byte(b, last);
   endtask

   task automatic send_bytes(input byte_queue_type frag);
      foreach (frag[i]) begin
         send_byte(frag[i], i == frag.size() - 1);
      end
   endtask

   // Stops offering bytes and waits until every predicted result has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // Writes the separator register once the parser has gone quiet.
   task automatic write_separator(input logic [BYTE_W-1:0] s);
      drain_results();
      // Bytes past the header cause no result but may still sit in the pipeline.
      repeat (4) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.separator_char <= s;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) begin
         @(posedge clock);
      end
      csr_ch.valid <= 1'b0;
      sb.set_separator(s);
   endtask

   // Builds one random fragment: mostly well-formed headers with random trailing bytes,
   // the rest with bad counts, bad separators, bad digits, cut short, or pure noise.
   function automatic byte_queue_type make_fragment(input logic [BYTE_W-1:0] sep);
      byte_queue_type    f;
      int                kind;
      int                idx;
      int                cnt;
      int                spot;
      logic [BYTE_W-1:0] junk;
      kind = $urandom_range(99);
      idx = $urandom_range(1294);
      cnt = $urandom_range(1295, idx + 1);
      if ($urandom_range(3) == 0) begin
         idx = $urandom_range(5);
         cnt = $urandom_range(8, idx + 1);
      end
      if (kind >= 55 && kind < 67) begin
         // Count zero or not above the index.
         idx = $urandom_range(1295);
         cnt = $urandom_range(idx);
      end
      f = '{digit_char(idx / 36), digit_char(idx % 36), sep,
            digit_char(cnt / 36), digit_char(cnt % 36), sep};
      if (kind >= 67 && kind < 77) begin
         // Corrupt one or both separators.
         spot = $urandom_range(1) ? 2 : 5;
         junk = 8'($urandom);
         f[spot] = (junk == sep) ? (junk ^ 8'h01) : junk;
         if ($urandom_range(2) == 0) begin
            spot = 7 - spot;
            junk = 8'($urandom);
            f[spot] = (junk == sep) ? (junk ^ 8'h80) : junk;
         end
      end else if (kind >= 77 && kind < 87) begin
         // Replace one digit with a byte just outside the digit ranges or a random one.
         spot = $urandom_range(3);
         if (spot >= 2) begin
            spot++;
         end
         case ($urandom_range(6))
            0: junk = "/";
            1: junk = ":";
            2: junk = "@";
            3: junk = "[";
            4: junk = "a";
            5: junk = "z";
            default: junk = 8'($urandom);
         endcase
         if (char_weight(junk) != 36) begin
            junk = "@";
         end
         f[spot] = junk;
      end else if (kind >= 87 && kind < 95) begin
         // Fragment ends inside the header.
         repeat (6 - $urandom_range(5, 1)) void'(f.pop_back());
      end else if (kind >= 95) begin
         f.delete();
         repeat ($urandom_range(8, 1)) f.push_back(8'($urandom));
      end
      if (kind < 87) begin
         repeat ($urandom_range(3)) f.push_back(8'($urandom));
      end
      return f;
   endfunction

   // Result side: check accepted results, then pick ready for the next cycle.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            sb.check_result('{status: rsp_ch.status, frag_index: rsp_ch.frag_index,
                              frag_count: rsp_ch.frag_count});
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !take_break();
         end
      end
   end

   // Stimulus: reset, a directed set under the reset separator, then random phases.
   initial begin
      byte_queue_type    frag;
      logic [BYTE_W-1:0] sep;
      int                phase_bytes;
      bit                hold_done;
      bit                pause_done;
      hold_done = 1'b0;
      pause_done = 1'b0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data_byte <= '0;
      req_ch.is_last <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.separator_char <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Good header with index YZ below the largest count ZZ.
      send_bytes('{"Y", "Z", 8'h00, "Z", "Z", 8'h00});
      // Bad digits and a bad separator together: the separator error wins.
      send_bytes('{"a", "0", "x", "1", "[", 8'h00});
      // Bad digit with a zero count, then a trailing byte that is ignored.
      send_bytes('{"0", ":", 8'h00, "0", "0", 8'h00, 8'hFF});
      // Index equal to count.
      send_bytes('{"1", "0", 8'h00, "1", "0", 8'h00});
      // Fragment ends on its first byte.
      send_bytes('{"Z"});

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: sep = 8'hFF;
            1: sep = "/";
            2: sep = 8'($urandom_range(255));
            3: sep = ":";
            4: sep = "A";
            default: sep = 8'h00;
         endcase
         write_separator(sep);
         steady_phase = (phase == 2);
         phase_bytes = 0;
         while (phase_bytes < 150) begin
            // Long receiver stall while bytes keep coming, so the input backs up.
            if (phase == 3 && !hold_done && phase_bytes >= 40) begin
               rsp_hold_cycles = 80;
               hold_done = 1'b1;
            end
            // Sender pause until the pipeline has emptied.
            if (phase == 4 && !pause_done && phase_bytes >= 60) begin
               drain_results();
               pause_done = 1'b1;
            end
            frag = make_fragment(sep);
            send_bytes(frag);
            phase_bytes += frag.size();
         end
      end
      steady_phase = 1'b0;

      req_ch.valid <= 1'b0;
      for (int n = 0; n < 20000 && sb.pending() != 0; n++) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.log_fault($sformatf("%0d expected results never arrived", sb.pending()));
      end
      if (sb.faults == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
